// ===== rtl/hermite_curve_sampler_unit_macros.svh =====
// Assertion macros used by the checker file of the curve sampler.
// No dependencies; include by bare file name.
`ifndef HERMITE_CURVE_SAMPLER_UNIT_MACROS_SVH
`define HERMITE_CURVE_SAMPLER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define HCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("curve sampler check failed");

// Check a consequence in the cycle after its trigger.
`define HCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("curve sampler check failed");

`endif

// ===== rtl/hcs_pkg.sv =====
// Shared widths and fixed-point constants of the Hermite curve sampler.
// No dependencies; used by hcs_axis_pipe and the top level.
`default_nettype none

package hcs_pkg;

    // coordinate and field widths
    localparam int W_CRD  = 16;
    localparam int W_IDX  = 4;
    localparam int N_AXES = 3;
    localparam int N_IN   = 12;

    // coefficient width: every Hermite coefficient of 16-bit operands fits
    localparam int W_COEF = 20;

    // t is Q1.16, 0 .. 1.0 inclusive
    localparam int FRAC  = 16;
    localparam int W_T   = FRAC + 1;
    localparam int ONE_T = 1 << FRAC;

    // Horner partial sums (Q.16), split point for the long multiplies
    localparam int W_H  = 38;
    localparam int LO   = 19;
    localparam int W_PH = W_H - LO + W_T + 1;
    localparam int W_PL = LO + W_T;
    localparam int W_P  = W_PH + LO;
    localparam int W_M1 = W_COEF + W_T + 1;

    // lane pipeline depth, in registers
    localparam int LAT = 7;

    // stream widths
    localparam int W_S_TDATA = N_IN * W_CRD;
    localparam int W_M_TDATA = 56;

    // coefficient set of one axis
    typedef struct packed {
        logic signed [W_COEF-1:0] a;
        logic signed [W_COEF-1:0] b;
        logic signed [W_COEF-1:0] c;
        logic signed [W_COEF-1:0] d;
    } t_coef;

endpackage

`default_nettype wire

// ===== rtl/hcs_axis_pipe.sv =====
// One axis of the Horner evaluation: ((a*t + b)*t + c)*t + d, rounded and clamped.
// Depends on hcs_pkg; seven registers deep, advances on i_ce.
`default_nettype none

module hcs_axis_pipe (
    input  wire logic                               i_clk,
    input  wire logic                               i_ce,
    input  wire hcs_pkg::t_coef                     i_coef,
    input  wire logic [hcs_pkg::W_T-1:0]            i_t,
    output logic signed [hcs_pkg::W_CRD-1:0]        o_point
);

    localparam int W_P  = hcs_pkg::W_P;
    localparam int W_H  = hcs_pkg::W_H;
    localparam int LO   = hcs_pkg::LO;
    localparam int FRAC = hcs_pkg::FRAC;
    localparam logic signed [W_P-1:0] HALF   = W_P'(1) <<< (FRAC - 1);
    localparam logic signed [W_P-1:0] SAT_HI = W_P'(32767);
    localparam logic signed [W_P-1:0] SAT_LO = W_P'(-32768);

    // sum split partial products, round off the fraction, add next coefficient
    function automatic logic signed [W_H-1:0] prod_round(
        input logic signed [hcs_pkg::W_PH-1:0]   pph,
        input logic        [hcs_pkg::W_PL-1:0]   ppl,
        input logic signed [hcs_pkg::W_COEF-1:0] addend
    );
        logic signed [W_P-1:0] s;
        s = $signed({pph, {LO{1'b0}}}) + $signed(W_P'(ppl));
        s = (s + HALF) >>> FRAC;
        s = s + (W_P'(addend) <<< FRAC);
        return s[W_H-1:0];
    endfunction

    // side registers
    logic        [hcs_pkg::W_T-1:0]    r_t [1:4];
    logic signed [hcs_pkg::W_COEF-1:0] r_b1;
    logic signed [hcs_pkg::W_COEF-1:0] r_c [1:3];
    logic signed [hcs_pkg::W_COEF-1:0] r_d [1:5];

    // stage registers
    logic signed [hcs_pkg::W_M1-1:0]   r_m1;
    logic signed [W_H-1:0]             r_h1;
    logic signed [hcs_pkg::W_PH-1:0]   r_pph1;
    logic        [hcs_pkg::W_PL-1:0]   r_ppl1;
    logic signed [W_H-1:0]             r_h2;
    logic signed [hcs_pkg::W_PH-1:0]   r_pph2;
    logic        [hcs_pkg::W_PL-1:0]   r_ppl2;
    logic signed [W_H-1:0]             r_h3;
    logic signed [hcs_pkg::W_CRD-1:0]  r_point;

    logic signed [W_P-1:0]             n_h1_sum;
    logic signed [W_H-LO-1:0]          w_hi1;
    logic signed [W_H-LO-1:0]          w_hi2;
    logic signed [W_P-1:0]             n_rnd;
    logic signed [hcs_pkg::W_CRD-1:0]  n_point;

    // first add, high halves of the long multiplies, final round and clamp
    always_comb begin
        n_h1_sum = W_P'(r_m1) + (W_P'(r_b1) <<< FRAC);
        w_hi1    = $signed(r_h1[W_H-1:LO]);
        w_hi2    = $signed(r_h2[W_H-1:LO]);
        n_rnd    = (W_P'(r_h3) + HALF) >>> FRAC;
        if (n_rnd > SAT_HI) begin
            n_point = hcs_pkg::W_CRD'(SAT_HI);
        end else if (n_rnd < SAT_LO) begin
            n_point = hcs_pkg::W_CRD'(SAT_LO);
        end else begin
            n_point = n_rnd[hcs_pkg::W_CRD-1:0];
        end
    end

    // advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_t[1] <= i_t;
            r_t[2] <= r_t[1];
            r_t[3] <= r_t[2];
            r_t[4] <= r_t[3];
            r_b1   <= i_coef.b;
            r_c[1] <= i_coef.c;
            r_c[2] <= r_c[1];
            r_c[3] <= r_c[2];
            r_d[1] <= i_coef.d;
            r_d[2] <= r_d[1];
            r_d[3] <= r_d[2];
            r_d[4] <= r_d[3];
            r_d[5] <= r_d[4];

            r_m1    <= i_coef.a * $signed({1'b0, i_t});
            r_h1    <= n_h1_sum[W_H-1:0];
            r_pph1  <= w_hi1 * $signed({1'b0, r_t[2]});
            r_ppl1  <= r_h1[LO-1:0] * r_t[2];
            r_h2    <= prod_round(r_pph1, r_ppl1, r_c[3]);
            r_pph2  <= w_hi2 * $signed({1'b0, r_t[4]});
            r_ppl2  <= r_h2[LO-1:0] * r_t[4];
            r_h3    <= prod_round(r_pph2, r_ppl2, r_d[5]);
            r_point <= n_point;
        end
    end

    assign o_point = r_point;

endmodule

`default_nettype wire

// ===== rtl/hermite_curve_sampler_unit.sv =====
// Hermite curve sampler: one 3D cubic Hermite curve in, STEPS+1 sampled points out.
// Depends on hcs_pkg and hcs_axis_pipe.
//
// Each input beat carries a curve (start point, end point, start tangent, end
// tangent); the block emits STEPS+1 output beats, points at t = k/STEPS for
// k = 0..STEPS, with tlast on the final point. A sample generator produces one
// point per cycle while the output is not stalled; the next curve is accepted
// in the cycle its predecessor's last point enters the pipeline. The first point
// of a curve passes the generator register, which loads the curve at the edge
// that accepts the input beat, and then the seven-register evaluation pipeline
// of each axis. An output stall freezes the whole pipeline in place.
`default_nettype none

module hermite_curve_sampler_unit #(
    parameter int STEPS = 10
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z, start_tan_x, start_tan_y,
    // start_tan_z, end_tan_x, end_tan_y, end_tan_z, 16 bits each from bit 0 up
    input  wire logic [hcs_pkg::W_S_TDATA-1:0]      i_s_tdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // point_x [15:0], point_y [31:16], point_z [47:32], sample_index [51:48], zeros
    output logic [hcs_pkg::W_M_TDATA-1:0]           o_m_tdata,
    // last_sample
    output logic                                    o_m_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready
);

    localparam int W_K   = (STEPS < 2) ? 1 : $clog2(STEPS + 1);
    localparam int W_REM = (STEPS < 2) ? 1 : $clog2(2 * STEPS);
    localparam int LAT   = hcs_pkg::LAT;
    localparam int W_CRD = hcs_pkg::W_CRD;
    localparam int W_C   = hcs_pkg::W_COEF;
    localparam logic [W_K-1:0]          K_LAST = W_K'(STEPS);
    localparam logic [hcs_pkg::W_T-1:0] T_STEP = hcs_pkg::W_T'(hcs_pkg::ONE_T / STEPS);
    localparam logic [W_REM-1:0]        T_REM  = W_REM'(hcs_pkg::ONE_T % STEPS);
    localparam logic [W_REM-1:0]        REM0   = W_REM'(STEPS / 2);
    localparam logic [W_REM-1:0]        STEPS_R = W_REM'(STEPS);

    logic                       w_ce;
    logic                       w_accept;

    // sample generator (stage 0)
    logic                       r_gen_vld;
    logic [W_K-1:0]             r_k;
    logic [hcs_pkg::W_T-1:0]    r_t;
    logic [W_REM-1:0]           r_rem;
    hcs_pkg::t_coef             r_coef [hcs_pkg::N_AXES];
    hcs_pkg::t_coef             n_coef [hcs_pkg::N_AXES];
    logic [W_REM-1:0]           n_rem_sum;

    // control pipeline beside the lanes
    logic                       r_vld  [1:LAT];
    logic [W_K-1:0]             r_kp   [1:LAT];
    logic                       r_last [1:LAT];

    logic signed [W_CRD-1:0]    w_point [hcs_pkg::N_AXES];
    logic [W_K+hcs_pkg::W_IDX-1:0] w_k_ext;

    // whole pipeline moves unless the output beat is held
    assign w_ce       = !r_vld[LAT] || i_m_tready;
    assign o_s_tready = w_ce && (!r_gen_vld || (r_k == K_LAST));
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign n_rem_sum  = r_rem + T_REM;

    // form Hermite coefficients per axis
    always_comb begin
        for (int ax = 0; ax < hcs_pkg::N_AXES; ax++) begin
            logic signed [W_C-1:0] p1;
            logic signed [W_C-1:0] p4;
            logic signed [W_C-1:0] r1;
            logic signed [W_C-1:0] r4;
            p1 = W_C'($signed(i_s_tdata[W_CRD*ax +: W_CRD]));
            p4 = W_C'($signed(i_s_tdata[W_CRD*(3+ax) +: W_CRD]));
            r1 = W_C'($signed(i_s_tdata[W_CRD*(6+ax) +: W_CRD]));
            r4 = W_C'($signed(i_s_tdata[W_CRD*(9+ax) +: W_CRD]));
            n_coef[ax].a = (p1 <<< 1) - (p4 <<< 1) + r1 + r4;
            n_coef[ax].b = (p4 - p1) * W_C'(3) - (r1 <<< 1) - r4;
            n_coef[ax].c = r1;
            n_coef[ax].d = p1;
        end
    end

    // load a curve or step t = k/STEPS with a running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_vld <= 1'b0;
            r_k       <= '0;
            r_t       <= '0;
            r_rem     <= REM0;
        end else if (w_ce) begin
            if (w_accept) begin
                r_gen_vld <= 1'b1;
                r_k       <= '0;
                r_t       <= '0;
                r_rem     <= REM0;
            end else if (r_gen_vld) begin
                if (r_k == K_LAST) begin
                    r_gen_vld <= 1'b0;
                end else begin
                    r_k <= r_k + W_K'(1);
                    if (n_rem_sum >= STEPS_R) begin
                        r_rem <= n_rem_sum - STEPS_R;
                        r_t   <= r_t + T_STEP + hcs_pkg::W_T'(1);
                    end else begin
                        r_rem <= n_rem_sum;
                        r_t   <= r_t + T_STEP;
                    end
                end
            end
        end
    end

    // hold coefficients of the curve in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int ax = 0; ax < hcs_pkg::N_AXES; ax++) begin
                r_coef[ax] <= n_coef[ax];
            end
        end
    end

    // carry valid, index and last flag alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_ce) begin
            r_vld[1] <= r_gen_vld;
            for (int s = 2; s <= LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_kp[1]   <= r_k;
            r_last[1] <= (r_k == K_LAST);
            for (int s = 2; s <= LAT; s++) begin
                r_kp[s]   <= r_kp[s-1];
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // one evaluation lane per axis
    for (genvar ax = 0; ax < hcs_pkg::N_AXES; ax++) begin : g_axis
        hcs_axis_pipe u_axis (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_coef  (r_coef[ax]),
            .i_t     (r_t),
            .o_point (w_point[ax])
        );
    end

    // pack the output beat
    assign w_k_ext    = {{hcs_pkg::W_IDX{1'b0}}, r_kp[LAT]};
    assign o_m_tvalid = r_vld[LAT];
    assign o_m_tlast  = r_last[LAT];
    assign o_m_tdata  = {{(hcs_pkg::W_M_TDATA - 3*W_CRD - hcs_pkg::W_IDX){1'b0}},
                         w_k_ext[hcs_pkg::W_IDX-1:0],
                         w_point[2], w_point[1], w_point[0]};

endmodule

`default_nettype wire

// ===== rtl/hcs_checker.sv =====
// Port-level checker for the Hermite curve sampler, bound to the top level.
// Depends on hcs_pkg and hermite_curve_sampler_unit_macros.svh.
`default_nettype none
`include "hermite_curve_sampler_unit_macros.svh"

module hcs_checker #(
    parameter int STEPS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [hcs_pkg::W_M_TDATA-1:0]  i_m_tdata,
    input  wire logic                           i_m_tlast,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready
);

    localparam int IDX_LSB = 3 * hcs_pkg::W_CRD;
    localparam logic [hcs_pkg::W_IDX-1:0] IDX_LAST = hcs_pkg::W_IDX'(STEPS);
    localparam logic [hcs_pkg::W_IDX-1:0] IDX_ZERO = '0;

    // a held output beat keeps its payload
    `HCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
    // a curve just taken closes the input behind it
    `HCS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)
    // the last point carries the final sample index
    `HCS_ASSERT_SAME(a_last_index, i_clk, i_rst_n, i_m_tvalid && i_m_tlast, i_m_tdata[IDX_LSB +: hcs_pkg::W_IDX] == IDX_LAST)
    // the first point of a curve never closes it, unless the final index wraps to zero
    `HCS_ASSERT_SAME(a_first_not_last, i_clk, i_rst_n, i_m_tvalid && (IDX_LAST != IDX_ZERO) && (i_m_tdata[IDX_LSB +: hcs_pkg::W_IDX] == IDX_ZERO), !i_m_tlast)

endmodule

bind hermite_curve_sampler_unit hcs_checker #(.STEPS(STEPS)) u_hcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire
